@@ rtl/bbc_pkg.sv @@
// bbc_pkg: shared types, codes and sizes for the bracket balance checker
// no dependencies; used by every module under rtl but bbc_ram
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 3;

  // bracket kinds held on the stack
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;

  // verdict codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_CLOSE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd5;

  // character codes
  localparam logic [7:0] CH_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] CH_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;

  typedef enum logic [1:0] {
    CLS_INVALID,
    CLS_OPEN,
    CLS_CLOSE
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [KIND_W-1:0] kind;
    logic              last;
  } op_t;

endpackage

@@ rtl/bracket_balance_checker.sv @@
// bracket_balance_checker: top level, front classifier, queue and stack engine
// depends on bbc_pkg, bbc_front, bbc_queue, bbc_back, bbc_ram
//
// channel  | dir | tdata                                   | tlast
// s_*      | in  | [7:0] char_code                         | last_char
// m_*      | out | [0] balanced, [3:1] status, [7:4] zero  | none
//
// one character per cycle while the queue has room; the back engine updates depth, top-of-stack
// register and error together, with the entry below the top read ahead from ram
// m_tvalid rises in the cycle after the back engine takes a string's last character from the queue
// rst clears depth, error, queue and output valid; the stack ram is never cleared
// a pending verdict holds the next last character at the queue head; characters ahead
// of it still flow, then the two-entry queue fills and s_tready drops
`timescale 1ns / 1ps

module bracket_balance_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,   // last_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] balanced, [3:1] status, [7:4] zero
);

  bbc_pkg::op_t front_op;
  bbc_pkg::op_t back_op;
  logic         q_push;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;

  bbc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (q_push),
    .op       (front_op)
  );

  bbc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (front_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_op  (back_op)
  );

  bbc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_op    (back_op),
    .in_take  (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ rtl/bbc_ram.sv @@
// bbc_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/bbc_front.sv @@
// bbc_front: accepts characters and classifies them into stack operations
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_front (
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           s_tlast,
  input  logic           q_full,
  output logic           push,
  output bbc_pkg::op_t   op
);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    op.last = s_tlast;
    op.cls  = bbc_pkg::CLS_INVALID;
    op.kind = bbc_pkg::KIND_ROUND;
    unique case (s_tdata)
      bbc_pkg::CH_ROUND_OPEN: begin
        op.cls  = bbc_pkg::CLS_OPEN;
        op.kind = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_SQUARE_OPEN: begin
        op.cls  = bbc_pkg::CLS_OPEN;
        op.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_CURLY_OPEN: begin
        op.cls  = bbc_pkg::CLS_OPEN;
        op.kind = bbc_pkg::KIND_CURLY;
      end
      bbc_pkg::CH_ROUND_CLOSE: begin
        op.cls  = bbc_pkg::CLS_CLOSE;
        op.kind = bbc_pkg::KIND_ROUND;
      end
      bbc_pkg::CH_SQUARE_CLOSE: begin
        op.cls  = bbc_pkg::CLS_CLOSE;
        op.kind = bbc_pkg::KIND_SQUARE;
      end
      bbc_pkg::CH_CURLY_CLOSE: begin
        op.cls  = bbc_pkg::CLS_CLOSE;
        op.kind = bbc_pkg::KIND_CURLY;
      end
      default: begin
        op.cls  = bbc_pkg::CLS_INVALID;
        op.kind = bbc_pkg::KIND_ROUND;
      end
    endcase
  end

endmodule

@@ rtl/bbc_queue.sv @@
// bbc_queue: two-entry queue of classified operations between front and back
// depends on bbc_pkg
`timescale 1ns / 1ps

module bbc_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bbc_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output bbc_pkg::op_t pop_op
);

  bbc_pkg::op_t entries [2];
  logic [1:0]   count;
  logic         wr_ptr;
  logic         rd_ptr;

  assign full   = (count == 2'd2);
  assign valid  = (count != 2'd0);
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end else begin
        count <= count;
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

@@ rtl/bbc_back.sv @@
// bbc_back: stack engine with top-of-stack register, stack ram and verdict register
// depends on bbc_pkg and bbc_ram
`timescale 1ns / 1ps

module bbc_back (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  bbc_pkg::op_t in_op,
  output logic         in_take,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata
);

  logic [bbc_pkg::DEPTH_W-1:0]  depth;
  logic [bbc_pkg::DEPTH_W-1:0]  depth_next;
  logic [bbc_pkg::DEPTH_W-1:0]  depth_op;
  logic [bbc_pkg::KIND_W-1:0]   top;
  logic [bbc_pkg::KIND_W-1:0]   top_next;
  logic [bbc_pkg::STATUS_W-1:0] err;
  logic [bbc_pkg::STATUS_W-1:0] err_op;
  logic [bbc_pkg::STATUS_W-1:0] err_next;
  logic [bbc_pkg::STATUS_W-1:0] verdict;
  logic [bbc_pkg::STATUS_W-1:0] status;
  logic                         balanced;
  logic                         fwd_hit;
  logic [bbc_pkg::KIND_W-1:0]   fwd_data;
  logic [bbc_pkg::KIND_W-1:0]   ram_rdata;
  logic [bbc_pkg::KIND_W-1:0]   below;
  logic                         we;
  logic [bbc_pkg::ADDR_W-1:0]   waddr;
  logic [bbc_pkg::ADDR_W-1:0]   raddr;
  logic                         out_free;
  logic                         done;

  // ram holds every entry under the top; the one just below the top is
  // read ahead each cycle, with a bypass for the entry written last cycle
  bbc_ram #(
    .WIDTH (bbc_pkg::KIND_W),
    .DEPTH (bbc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign below    = fwd_hit ? fwd_data : ram_rdata;
  assign out_free = !m_tvalid || m_tready;
  assign in_take  = in_valid && (!in_op.last || out_free);
  assign done     = in_take && in_op.last;
  assign waddr    = bbc_pkg::ADDR_W'(depth - bbc_pkg::DEPTH_W'(1));

  always_comb begin
    depth_op = depth;
    top_next = top;
    err_op   = err;
    we       = 1'b0;
    if (in_take && err == bbc_pkg::ST_OK) begin
      unique case (in_op.cls)
        bbc_pkg::CLS_OPEN: begin
          if (depth == bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH)) begin
            err_op = bbc_pkg::ST_OVERFLOW;
          end else begin
            we       = (depth != '0);
            top_next = in_op.kind;
            depth_op = depth + bbc_pkg::DEPTH_W'(1);
          end
        end
        bbc_pkg::CLS_CLOSE: begin
          if (depth == '0) begin
            err_op = bbc_pkg::ST_EMPTY_CLOSE;
          end else if (top != in_op.kind) begin
            err_op = bbc_pkg::ST_MISMATCH;
          end else begin
            top_next = below;
            depth_op = depth - bbc_pkg::DEPTH_W'(1);
          end
        end
        default: begin
          err_op = bbc_pkg::ST_INVALID;
        end
      endcase
    end

    priority if (err_op != bbc_pkg::ST_OK) begin
      verdict = err_op;
    end else if (depth_op != '0) begin
      verdict = bbc_pkg::ST_UNCLOSED;
    end else begin
      verdict = bbc_pkg::ST_OK;
    end

    depth_next = done ? '0 : depth_op;
    err_next   = done ? bbc_pkg::ST_OK : err_op;
    raddr      = bbc_pkg::ADDR_W'(depth_next - bbc_pkg::DEPTH_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= '0;
      err      <= bbc_pkg::ST_OK;
      m_tvalid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      depth   <= depth_next;
      err     <= err_next;
      fwd_hit <= we && (waddr == raddr);
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top      <= top_next;
    fwd_data <= top;
    if (done) begin
      status   <= verdict;
      balanced <= (verdict == bbc_pkg::ST_OK);
    end
  end

  assign m_tdata = {4'b0000, status, balanced};

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    done |=> (depth == '0 && err == bbc_pkg::ST_OK))
    else $error("state not cleared after verdict");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != bbc_pkg::ST_OK && !done) |=> (err == $past(err)))
    else $error("latched error changed within a string");
  a_verdict_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (balanced == (status == bbc_pkg::ST_OK)))
    else $error("balanced flag disagrees with status");

endmodule

@@ tb/testbench.sv @@
// testbench for bracket_balance_checker: streams strings of brackets and noise bytes,
// predicts every verdict in a scoreboard class and compares each verdict transfer
// depends on bbc_pkg and bracket_balance_checker
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic                         balanced;
    logic [bbc_pkg::STATUS_W-1:0] status;
  } verdict_t;

  // tracks the open-bracket stack per string and queues the verdicts still due
  class verdict_book_t;
    logic [bbc_pkg::KIND_W-1:0]   kinds[bbc_pkg::STACK_DEPTH];
    int unsigned                  depth = 0;
    logic [bbc_pkg::STATUS_W-1:0] err = bbc_pkg::ST_OK;
    verdict_t                     verdicts_due[$];
    int                           errors = 0;

    function void take_char(logic [7:0] c, logic last);
      bbc_pkg::cls_t              cls;
      logic [bbc_pkg::KIND_W-1:0] kind;
      verdict_t                   v;
      cls  = bbc_pkg::CLS_INVALID;
      kind = bbc_pkg::KIND_ROUND;
      case (c)
        bbc_pkg::CH_ROUND_OPEN: begin
          cls  = bbc_pkg::CLS_OPEN;
          kind = bbc_pkg::KIND_ROUND;
        end
        bbc_pkg::CH_SQUARE_OPEN: begin
          cls  = bbc_pkg::CLS_OPEN;
          kind = bbc_pkg::KIND_SQUARE;
        end
        bbc_pkg::CH_CURLY_OPEN: begin
          cls  = bbc_pkg::CLS_OPEN;
          kind = bbc_pkg::KIND_CURLY;
        end
        bbc_pkg::CH_ROUND_CLOSE: begin
          cls  = bbc_pkg::CLS_CLOSE;
          kind = bbc_pkg::KIND_ROUND;
        end
        bbc_pkg::CH_SQUARE_CLOSE: begin
          cls  = bbc_pkg::CLS_CLOSE;
          kind = bbc_pkg::KIND_SQUARE;
        end
        bbc_pkg::CH_CURLY_CLOSE: begin
          cls  = bbc_pkg::CLS_CLOSE;
          kind = bbc_pkg::KIND_CURLY;
        end
        default: cls = bbc_pkg::CLS_INVALID;
      endcase
      // first error of a string freezes the stack until the verdict
      if (err == bbc_pkg::ST_OK) begin
        case (cls)
          bbc_pkg::CLS_INVALID: err = bbc_pkg::ST_INVALID;
          bbc_pkg::CLS_OPEN: begin
            if (depth >= bbc_pkg::STACK_DEPTH) begin
              err = bbc_pkg::ST_OVERFLOW;
            end else begin
              kinds[depth] = kind;
              depth++;
            end
          end
          default: begin
            if (depth == 0) err = bbc_pkg::ST_EMPTY_CLOSE;
            else if (kinds[depth-1] != kind) err = bbc_pkg::ST_MISMATCH;
            else depth--;
          end
        endcase
      end
      if (last) begin
        if (err != bbc_pkg::ST_OK) v.status = err;
        else if (depth != 0) v.status = bbc_pkg::ST_UNCLOSED;
        else v.status = bbc_pkg::ST_OK;
        v.balanced = (v.status == bbc_pkg::ST_OK);
        verdicts_due.push_back(v);
        depth = 0;
        err   = bbc_pkg::ST_OK;
      end
    endfunction

    function void check_verdict(logic [7:0] d);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $display("%0t: verdict with none due, actual tdata %h", $time, d);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (d[0] !== want.balanced) begin
        $display("%0t: balanced expected %b actual %b", $time, want.balanced, d[0]);
        errors++;
      end
      if (d[3:1] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, d[3:1]);
        errors++;
      end
      if (d[7:4] !== 4'd0) begin
        $display("%0t: pad bits expected 0 actual %h", $time, d[7:4]);
        errors++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  wire        s_tready;
  wire        m_tvalid;
  wire  [7:0] m_tdata;

  verdict_book_t book = new;
  logic [7:0]    line_q[$];
  int            burst_left = 0;
  int            chars_sent = 0;
  bit            hold_req = 0;
  int            hold_left = 0;
  int            rx_mode = 0;
  int            rx_mode_left = 0;
  int            rx_phase = 0;
  bit            pressure_done = 0;

  bracket_balance_checker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_phase % 7) > 2;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_verdict(m_tdata);
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] opener_of(int k);
    case (k)
      0: return bbc_pkg::CH_ROUND_OPEN;
      1: return bbc_pkg::CH_SQUARE_OPEN;
      default: return bbc_pkg::CH_CURLY_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] closer_of(int k);
    case (k)
      0: return bbc_pkg::CH_ROUND_CLOSE;
      1: return bbc_pkg::CH_SQUARE_CLOSE;
      default: return bbc_pkg::CH_CURLY_CLOSE;
    endcase
  endfunction

  // sender works in bursts with random gaps in between
  task automatic send_char(input logic [7:0] c, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    book.take_char(c, l);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
  endtask

  // random well-formed string: n_open pairs, nesting never above max_open
  task automatic gen_balanced(input int max_open, input int n_open);
    int open_q[$];
    int left;
    int k;
    left = n_open;
    line_q.delete();
    while (left > 0 || open_q.size() > 0) begin
      if (left > 0 && (open_q.size() == 0 ||
                       (open_q.size() < max_open && $urandom_range(0, 1)))) begin
        k = $urandom_range(0, 2);
        open_q.push_back(k);
        line_q.push_back(opener_of(k));
        left--;
      end else begin
        line_q.push_back(closer_of(open_q.pop_back()));
      end
    end
  endtask

  // n openers straight down, then all closers
  task automatic gen_nest(input int n);
    int open_q[$];
    int k;
    line_q.delete();
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 2);
      open_q.push_back(k);
      line_q.push_back(opener_of(k));
    end
    while (open_q.size() > 0) line_q.push_back(closer_of(open_q.pop_back()));
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 6);
    line_q.delete();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) line_q.push_back(closer_of($urandom_range(0, 2)));
      else line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // breaks a well-formed string in one of several ways, or leaves it alone
  task automatic mutate(input int how);
    int idx;
    idx = $urandom_range(0, line_q.size() - 1);
    case (how)
      5: line_q[idx] = 8'($urandom_range(0, 255));
      6: line_q[idx] = closer_of($urandom_range(0, 2));
      7: if (line_q.size() > 1) void'(line_q.pop_back());
      8: line_q.push_front(closer_of($urandom_range(0, 2)));
      9: line_q.push_back(($urandom_range(0, 1)) ? closer_of($urandom_range(0, 2))
                                                   : opener_of($urandom_range(0, 2)));
      default: ;
    endcase
  endtask

  initial begin
    int pick;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    send_text("()");
    send_text("[{()}]");
    send_text(")");
    send_text("(]");
    send_text("{(");
    send_text("x");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_text("(x)");
    send_text("()]");
    send_text("[)");

    // stack exactly full, then one opener too many
    gen_nest(bbc_pkg::STACK_DEPTH);
    send_line();
    gen_nest(bbc_pkg::STACK_DEPTH + 1);
    send_line();

    while (chars_sent < 1370) begin
      pick = $urandom_range(0, 199);
      if (pick < 16) gen_noise();
      else if (pick == 16) gen_nest(bbc_pkg::STACK_DEPTH);
      else if (pick == 17)
        gen_nest($urandom_range(bbc_pkg::STACK_DEPTH + 1, bbc_pkg::STACK_DEPTH + 3));
      else begin
        gen_balanced($urandom_range(1, 8), $urandom_range(1, 8));
        mutate($urandom_range(0, 9));
      end
      send_line();

      // receiver holds off while short strings pile up behind the pending verdict
      if (!pressure_done && chars_sent > 500) begin
        pressure_done = 1;
        hold_req      = 1;
        for (int i = 0; i < 24; i++) send_text((i % 2) ? "[]" : "()");
      end
    end

    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bbc_pkg.sv
rtl/bbc_ram.sv
rtl/bbc_front.sv
rtl/bbc_queue.sv
rtl/bbc_back.sv
rtl/bracket_balance_checker.sv
tb/testbench.sv
